// ===== sv/imm_pkg.sv =====
// Shared types and constants for the integer matrix multiply unit.
// Used by imm_cell, imm_seq and integer_matrix_multiply_unit; no dependencies.
package imm_pkg;

	localparam int MAX_DIM_DEF = 64;
	localparam int IDX_W = 6;
	localparam int VAL_W = 32;
	localparam int REG_W = 7;

	// action codes carried in s_axis_tuser
	localparam logic [1:0] ACT_WR_A = 2'd0;
	localparam logic [1:0] ACT_WR_B = 2'd1;
	localparam logic [1:0] ACT_COMP = 2'd2;

	// register indexes, taken from paddr[3:2]
	localparam logic [1:0] REG_A_ROWS = 2'd0;
	localparam logic [1:0] REG_INNER = 2'd1;
	localparam logic [1:0] REG_B_COLS = 2'd2;

	localparam logic [REG_W-1:0] REG_RESET = 7'd64;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic clear;
		logic shift;
		logic wr_en;
		logic [IDX_W-1:0] wr_row;
		logic [IDX_W-1:0] wr_col;
		logic [VAL_W-1:0] wr_data;
	} bcast_t;

	// one term handed from cell to cell: A element and its inner index
	typedef struct packed {
		logic valid;
		logic [VAL_W-1:0] a;
		logic [IDX_W-1:0] k;
	} link_t;

endpackage

// ===== sv/imm_cell.sv =====
// One multiply-accumulate cell: owns one column of B and one result accumulator.
// Depends on imm_pkg (bcast_t, link_t).
module imm_cell #(
	parameter int AW = 6,
	parameter int COL_IDX = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  imm_pkg::bcast_t bcast,
	input  imm_pkg::link_t link_in,
	output imm_pkg::link_t link_out,
	input  logic [imm_pkg::VAL_W-1:0] acc_in,
	output logic [imm_pkg::VAL_W-1:0] acc_out
);

	logic [imm_pkg::VAL_W-1:0] bmem [2**AW];
	logic [imm_pkg::VAL_W-1:0] b_s1;
	logic [imm_pkg::VAL_W-1:0] a_s1;
	logic v_s1;
	logic [imm_pkg::VAL_W-1:0] prod_s2;
	logic v_s2;
	logic [imm_pkg::VAL_W-1:0] acc_q;
	imm_pkg::link_t link_q;

	always_ff @(posedge clk) begin
		if (bcast.wr_en && bcast.wr_col == imm_pkg::IDX_W'(COL_IDX)) begin
			bmem[bcast.wr_row[AW-1:0]] <= bcast.wr_data;
		end
		b_s1 <= bmem[link_in.k[AW-1:0]];
		a_s1 <= link_in.a;
		prod_s2 <= a_s1 * b_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			link_q <= '0;
		end else if (bcast.clear) begin
			// drop terms of the previous row still moving down the chain
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			link_q <= '0;
		end else begin
			v_s1 <= link_in.valid;
			v_s2 <= v_s1;
			link_q <= link_in;
		end
	end

	// shift moves results toward cell 0 during unload
	always_ff @(posedge clk) begin
		if (bcast.clear) begin
			acc_q <= '0;
		end else if (bcast.shift) begin
			acc_q <= acc_in;
		end else if (v_s2) begin
			acc_q <= acc_q + prod_s2;
		end
	end

	assign link_out = link_q;
	assign acc_out = acc_q;

endmodule

// ===== sv/imm_seq.sv =====
// Sequencer: input handshake, A store, term issue into the cell chain,
// result unload and output register. Depends on imm_pkg.
module imm_seq #(
	parameter int LIM = 64,
	parameter int AW = 6
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [47:0] s_axis_tdata,
	input  logic [1:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [47:0] m_axis_tdata,
	output logic m_axis_tlast,
	output logic [0:0] m_axis_tuser,
	input  logic [imm_pkg::REG_W-1:0] rows_eff,
	input  logic [imm_pkg::REG_W-1:0] klen_eff,
	input  logic [imm_pkg::REG_W-1:0] cols_eff,
	output imm_pkg::bcast_t bcast,
	output imm_pkg::link_t link0,
	input  logic [imm_pkg::VAL_W-1:0] acc0
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ISSUE = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_UNLOAD = 3'd3;
	localparam logic [2:0] ST_BAD = 3'd4;
	localparam logic [imm_pkg::REG_W-1:0] LIM_V = imm_pkg::REG_W'(LIM);

	logic [2:0] state_q;
	logic [imm_pkg::IDX_W-1:0] row_q;
	logic [imm_pkg::IDX_W-1:0] k_q;
	logic [imm_pkg::IDX_W-1:0] j_q;
	logic [imm_pkg::REG_W-1:0] cnt_q;

	logic [imm_pkg::VAL_W-1:0] amem [2**(2*AW)];
	logic [imm_pkg::VAL_W-1:0] a_s1;
	logic [imm_pkg::IDX_W-1:0] k_s1;
	logic iss_v_s1;

	logic mv_q;
	logic [imm_pkg::IDX_W-1:0] mrow_q;
	logic [imm_pkg::IDX_W-1:0] mcol_q;
	logic [imm_pkg::VAL_W-1:0] mval_q;
	logic mlast_q;
	logic mbad_q;

	logic [imm_pkg::IDX_W-1:0] in_row;
	logic [imm_pkg::IDX_W-1:0] in_col;
	logic [imm_pkg::VAL_W-1:0] in_val;
	logic take;
	logic in_rng;
	logic row_ok;
	logic out_free;
	logic issue;
	logic last_k;
	logic last_j;
	logic ld;

	assign in_row = s_axis_tdata[5:0];
	assign in_col = s_axis_tdata[11:6];
	assign in_val = s_axis_tdata[43:12];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign take = s_axis_tvalid && s_axis_tready;
	assign in_rng = ({1'b0, in_row} < LIM_V) && ({1'b0, in_col} < LIM_V);
	assign row_ok = {1'b0, in_row} < rows_eff;
	assign out_free = !mv_q || m_axis_tready;
	assign issue = (state_q == ST_ISSUE);
	assign last_k = ({1'b0, k_q} + 7'd1) == klen_eff;
	assign last_j = ({1'b0, j_q} + 7'd1) == cols_eff;
	assign ld = ((state_q == ST_UNLOAD) || (state_q == ST_BAD)) && out_free;

	always_comb begin
		bcast.clear = take && s_axis_tuser == imm_pkg::ACT_COMP;
		bcast.shift = (state_q == ST_UNLOAD) && out_free;
		bcast.wr_en = take && s_axis_tuser == imm_pkg::ACT_WR_B && in_rng;
		bcast.wr_row = in_row;
		bcast.wr_col = in_col;
		bcast.wr_data = in_val;
	end

	always_ff @(posedge clk) begin
		if (take && s_axis_tuser == imm_pkg::ACT_WR_A && in_rng) begin
			amem[{in_row[AW-1:0], in_col[AW-1:0]}] <= in_val;
		end
		a_s1 <= amem[{row_q[AW-1:0], k_q[AW-1:0]}];
		k_s1 <= k_q;
	end

	assign link0.valid = iss_v_s1;
	assign link0.a = a_s1;
	assign link0.k = k_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q <= '0;
			k_q <= '0;
			j_q <= '0;
			cnt_q <= '0;
			iss_v_s1 <= 1'b0;
		end else begin
			iss_v_s1 <= issue;
			case (state_q)
				ST_IDLE: begin
					if (take && s_axis_tuser == imm_pkg::ACT_COMP) begin
						row_q <= in_row;
						k_q <= '0;
						j_q <= '0;
						cnt_q <= '0;
						if (!row_ok) begin
							state_q <= ST_BAD;
						end else if (cols_eff == '0) begin
							state_q <= ST_IDLE;
						end else if (klen_eff == '0) begin
							state_q <= ST_DRAIN;
						end else begin
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_ISSUE: begin
					k_q <= k_q + 6'd1;
					if (last_k) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// wait for the last term to reach the far cell's accumulator
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == cols_eff + 7'd2) begin
						state_q <= ST_UNLOAD;
					end
				end
				ST_UNLOAD: begin
					if (out_free) begin
						j_q <= j_q + 6'd1;
						if (last_j) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_BAD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_q <= 1'b0;
		end else if (ld) begin
			mv_q <= 1'b1;
		end else if (m_axis_tready) begin
			mv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			mrow_q <= row_q;
			if (state_q == ST_BAD) begin
				mcol_q <= '0;
				mval_q <= '0;
				mlast_q <= 1'b1;
				mbad_q <= 1'b1;
			end else begin
				mcol_q <= j_q;
				mval_q <= acc0;
				mlast_q <= last_j;
				mbad_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = mv_q;
	assign m_axis_tdata = {4'b0, mval_q, mcol_q, mrow_q};
	assign m_axis_tlast = mlast_q;
	assign m_axis_tuser = mbad_q;

endmodule

// ===== sv/integer_matrix_multiply_unit.sv =====
// Top level of the integer matrix multiply unit: register port, sequencer and
// a chain of multiply-accumulate cells. Depends on imm_pkg, imm_seq, imm_cell.
//
// channel   direction  handshake                  payload
// s_axis    in         tvalid/tready              tuser=action, tdata=row,col,value
// m_axis    out        tvalid/tready              tdata=row,col,value, tlast, tuser=bad_row
// apb       in         psel&penable&pwrite        a_rows@0, inner_len@4, b_cols@8
//
// A load request is accepted in idle and leaves the unit idle. A compute request
// passes, from its accept to the next accept, through acceptance, a stream of the
// A row through the single A-store read port, a drain of the cell chain, and a shift
// of the results out. Output stalls hold the unload. Reset clears control
// state; the A and B stores are not cleared. A bad row emits one bad_row result, and a
// valid row with b_cols zero returns straight to idle.
module integer_matrix_multiply_unit #(
	parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // row_index[5:0], col_index[11:6], elem_value[43:12]
	input  logic [1:0] s_axis_tuser,   // action[1:0]
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [47:0] m_axis_tdata,  // out_row[5:0], out_col[11:6], out_value[43:12]
	output logic m_axis_tlast,
	output logic [0:0] m_axis_tuser,   // bad_row[0]
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam int LIM = (MAX_DIM < 64) ? MAX_DIM : 64;
	localparam int AW = $clog2(LIM);
	localparam logic [imm_pkg::REG_W-1:0] LIM_V = imm_pkg::REG_W'(LIM);

	logic [imm_pkg::REG_W-1:0] a_rows_q;
	logic [imm_pkg::REG_W-1:0] inner_q;
	logic [imm_pkg::REG_W-1:0] b_cols_q;
	logic [imm_pkg::REG_W-1:0] rows_eff;
	logic [imm_pkg::REG_W-1:0] klen_eff;
	logic [imm_pkg::REG_W-1:0] cols_eff;
	logic wr;

	imm_pkg::bcast_t bcast;
	imm_pkg::link_t links [LIM+1];
	logic [imm_pkg::VAL_W-1:0] accs [LIM+1];

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q <= imm_pkg::REG_RESET;
			inner_q <= imm_pkg::REG_RESET;
			b_cols_q <= imm_pkg::REG_RESET;
		end else if (wr) begin
			case (paddr[3:2])
				imm_pkg::REG_A_ROWS: a_rows_q <= pwdata[imm_pkg::REG_W-1:0];
				imm_pkg::REG_INNER: inner_q <= pwdata[imm_pkg::REG_W-1:0];
				imm_pkg::REG_B_COLS: b_cols_q <= pwdata[imm_pkg::REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			imm_pkg::REG_A_ROWS: prdata = {25'b0, a_rows_q};
			imm_pkg::REG_INNER: prdata = {25'b0, inner_q};
			imm_pkg::REG_B_COLS: prdata = {25'b0, b_cols_q};
			default: prdata = '0;
		endcase
	end

	// saturate each dimension at what the stores hold
	assign rows_eff = (a_rows_q > LIM_V) ? LIM_V : a_rows_q;
	assign klen_eff = (inner_q > LIM_V) ? LIM_V : inner_q;
	assign cols_eff = (b_cols_q > LIM_V) ? LIM_V : b_cols_q;

	imm_seq #(
		.LIM(LIM),
		.AW(AW)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser),
		.rows_eff(rows_eff),
		.klen_eff(klen_eff),
		.cols_eff(cols_eff),
		.bcast(bcast),
		.link0(links[0]),
		.acc0(accs[0])
	);

	assign accs[LIM] = '0;

	for (genvar c = 0; c < LIM; c++) begin : g_cell
		imm_cell #(
			.AW(AW),
			.COL_IDX(c)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.bcast(bcast),
			.link_in(links[c]),
			.link_out(links[c+1]),
			.acc_in(accs[c+1]),
			.acc_out(accs[c])
		);
	end

endmodule

// ===== tb/sv/integer_matrix_multiply_unit_tb.sv =====
// Self-checking testbench for integer_matrix_multiply_unit: loads A and B
// elements, requests result rows and checks every result against a local model.
// Depends on imm_pkg and the RTL of integer_matrix_multiply_unit only.
`timescale 1ns / 1ps

module integer_matrix_multiply_unit_tb;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 250;
	localparam int RANDOM_ITEMS = 70;

	typedef struct packed {
		logic [imm_pkg::IDX_W-1:0] row;
		logic [imm_pkg::IDX_W-1:0] col;
		logic [imm_pkg::VAL_W-1:0] value;
		logic last;
		logic bad;
	} row_result_t;

	typedef enum logic {STEP_REG, STEP_REQ} step_kind_e;

	typedef struct {
		step_kind_e kind;
		logic [1:0] code;
		logic [imm_pkg::IDX_W-1:0] row;
		logic [imm_pkg::IDX_W-1:0] col;
		logic [imm_pkg::VAL_W-1:0] value;
		bit typed;
		row_result_t want;
	} dir_step_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [47:0] s_axis_tdata;  // row_index[5:0], col_index[11:6], elem_value[43:12]
	logic [1:0] s_axis_tuser;   // action[1:0]
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [47:0] m_axis_tdata;  // out_row[5:0], out_col[11:6], out_value[43:12]
	logic m_axis_tlast;
	logic [0:0] m_axis_tuser;   // bad_row[0]
	logic psel;
	logic penable;
	logic pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	integer_matrix_multiply_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// local copy of the element stores and the registers
	logic [imm_pkg::VAL_W-1:0] a_mirror [imm_pkg::MAX_DIM_DEF][imm_pkg::MAX_DIM_DEF];
	logic [imm_pkg::VAL_W-1:0] b_mirror [imm_pkg::MAX_DIM_DEF][imm_pkg::MAX_DIM_DEF];
	bit a_written [imm_pkg::MAX_DIM_DEF][imm_pkg::MAX_DIM_DEF];
	bit b_written [imm_pkg::MAX_DIM_DEF][imm_pkg::MAX_DIM_DEF];
	logic [imm_pkg::REG_W-1:0] cfg_a_rows = imm_pkg::REG_RESET;
	logic [imm_pkg::REG_W-1:0] cfg_inner = imm_pkg::REG_RESET;
	logic [imm_pkg::REG_W-1:0] cfg_b_cols = imm_pkg::REG_RESET;

	row_result_t row_results [$];
	dir_step_t plan [$];
	row_result_t got;
	row_result_t want;
	int fail_count = 0;
	int results_seen = 0;
	int requests_sent = 0;
	int settings_used = 0;
	bit gaps_on = 1'b1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= !(gaps_on && $urandom_range(99) < 32);
	end

	function automatic row_result_t mk_result(logic [imm_pkg::IDX_W-1:0] row,
			logic [imm_pkg::IDX_W-1:0] col, logic [imm_pkg::VAL_W-1:0] value,
			logic last, logic bad);
		row_result_t r;
		r.row = row;
		r.col = col;
		r.value = value;
		r.last = last;
		r.bad = bad;
		return r;
	endfunction

	function automatic int clip_dim(logic [imm_pkg::REG_W-1:0] v);
		return (v > imm_pkg::MAX_DIM_DEF) ? imm_pkg::MAX_DIM_DEF : int'(v);
	endfunction

	function automatic logic [imm_pkg::VAL_W-1:0] rand_elem();
		case ($urandom_range(3))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($signed($urandom_range(200)) - 100);
			default: return $urandom;
		endcase
	endfunction

	// mostly small sizes, now and then zero, the top value or beyond it
	function automatic logic [imm_pkg::REG_W-1:0] pick_dim();
		case ($urandom_range(19))
			0: return 7'd0;
			1: return 7'd64;
			2: return 7'($urandom_range(65, 127));
			default: return 7'($urandom_range(1, 6));
		endcase
	endfunction

	function automatic dir_step_t step_of(step_kind_e kind, logic [1:0] code,
			logic [imm_pkg::IDX_W-1:0] row, logic [imm_pkg::IDX_W-1:0] col,
			logic [imm_pkg::VAL_W-1:0] value, bit typed, row_result_t want);
		dir_step_t s;
		s.kind = kind;
		s.code = code;
		s.row = row;
		s.col = col;
		s.value = value;
		s.typed = typed;
		s.want = want;
		return s;
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			fail_count++;
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
		end
	endfunction

	// update the mirrors for an accepted request and queue the results it causes
	task automatic predict_request(logic [1:0] act, logic [imm_pkg::IDX_W-1:0] row,
			logic [imm_pkg::IDX_W-1:0] col, logic [imm_pkg::VAL_W-1:0] value, bit typed,
			row_result_t want);
		int rows;
		int klen;
		int cols;
		logic [imm_pkg::VAL_W-1:0] acc;
		rows = clip_dim(cfg_a_rows);
		klen = clip_dim(cfg_inner);
		cols = clip_dim(cfg_b_cols);
		case (act)
			imm_pkg::ACT_WR_A: begin
				a_mirror[row][col] = value;
				a_written[row][col] = 1'b1;
			end
			imm_pkg::ACT_WR_B: begin
				b_mirror[row][col] = value;
				b_written[row][col] = 1'b1;
			end
			imm_pkg::ACT_COMP: begin
				if (typed)
					row_results.push_back(want);
				else if (row >= rows)
					row_results.push_back(mk_result(row, '0, '0, 1'b1, 1'b1));
				else begin
					for (int j = 0; j < cols; j++) begin
						acc = '0;
						for (int k = 0; k < klen; k++)
							acc = acc + a_mirror[row][k] * b_mirror[k][j];
						row_results.push_back(mk_result(row, imm_pkg::IDX_W'(j), acc,
							j == cols - 1, 1'b0));
					end
				end
			end
			default: ;
		endcase
	endtask

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic push_request(logic [1:0] act, logic [imm_pkg::IDX_W-1:0] row,
			logic [imm_pkg::IDX_W-1:0] col, logic [imm_pkg::VAL_W-1:0] value, bit typed,
			row_result_t want);
		while (gaps_on && $urandom_range(99) < 32) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, value, col, row};
		s_axis_tuser <= act;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_request(act, row, col, value, typed, want);
		requests_sent++;
		@(negedge clk);
	endtask

	// write any operand the row will read that has not been written yet
	task automatic fill_operands(logic [imm_pkg::IDX_W-1:0] row);
		int klen;
		int cols;
		if (row >= clip_dim(cfg_a_rows))
			return;
		klen = clip_dim(cfg_inner);
		cols = clip_dim(cfg_b_cols);
		for (int k = 0; k < klen; k++) begin
			if (!a_written[row][k])
				push_request(imm_pkg::ACT_WR_A, row, imm_pkg::IDX_W'(k), rand_elem(), 1'b0, '0);
			for (int j = 0; j < cols; j++)
				if (!b_written[k][j])
					push_request(imm_pkg::ACT_WR_B, imm_pkg::IDX_W'(k), imm_pkg::IDX_W'(j),
						rand_elem(), 1'b0, '0);
		end
	endtask

	// drop valid, let every expected result drain and the block go quiet
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (row_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// returns at the falling edge after the bus went idle
	task automatic reg_access(bit wr, logic [1:0] idx, logic [31:0] value,
			output logic [31:0] rd);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic read_reg(logic [1:0] idx, logic [imm_pkg::REG_W-1:0] exp_v);
		logic [31:0] rd;
		reg_access(1'b0, idx, '0, rd);
		check_field("register readback", 32'(exp_v), 32'(rd[imm_pkg::REG_W-1:0]));
	endtask

	task automatic write_reg(logic [1:0] idx, logic [imm_pkg::REG_W-1:0] value);
		logic [31:0] rd;
		settle();
		reg_access(1'b1, idx, 32'(value), rd);
		case (idx)
			imm_pkg::REG_A_ROWS: cfg_a_rows = value;
			imm_pkg::REG_INNER: cfg_inner = value;
			imm_pkg::REG_B_COLS: cfg_b_cols = value;
			default: ;
		endcase
		settings_used++;
		read_reg(idx, value);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = mk_result(m_axis_tdata[5:0], m_axis_tdata[11:6], m_axis_tdata[43:12],
				m_axis_tlast, m_axis_tuser[0]);
			results_seen++;
			if (row_results.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected result: expected none, actual row %0d col %0d value %h",
					$time, got.row, got.col, got.value);
			end else begin
				want = row_results.pop_front();
				check_field("out_row", 32'(want.row), 32'(got.row));
				check_field("out_col", 32'(want.col), 32'(got.col));
				check_field("out_value", want.value, got.value);
				check_field("last_in_row", 32'(want.last), 32'(got.last));
				check_field("bad_row", 32'(want.bad), 32'(got.bad));
			end
		end
	end

	initial begin
		#10ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int random_sent;
		int stop_at;
		int picks;
		int phase;
		int rows;
		int pick;
		logic [imm_pkg::IDX_W-1:0] row;
		logic [imm_pkg::REG_W-1:0] dim_a;
		logic [imm_pkg::REG_W-1:0] dim_k;
		logic [imm_pkg::REG_W-1:0] dim_n;

		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = imm_pkg::ACT_WR_A;
		m_axis_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		read_reg(imm_pkg::REG_A_ROWS, imm_pkg::REG_RESET);
		read_reg(imm_pkg::REG_INNER, imm_pkg::REG_RESET);
		read_reg(imm_pkg::REG_B_COLS, imm_pkg::REG_RESET);

		// directed part: field extremes, every action, each corner of the sizes
		plan.push_back(step_of(STEP_REG, imm_pkg::REG_A_ROWS, 0, 0, 2, 0, '0));
		plan.push_back(step_of(STEP_REG, imm_pkg::REG_INNER, 0, 0, 2, 0, '0));
		plan.push_back(step_of(STEP_REG, imm_pkg::REG_B_COLS, 0, 0, 2, 0, '0));
		plan.push_back(step_of(STEP_REQ, imm_pkg::ACT_WR_A, 0, 0, 32'h7FFF_FFFF, 0, '0));
		plan.push_back(step_of(STEP_REQ, imm_pkg::ACT_WR_A, 0, 1, 32'h8000_0000, 0, '0));
		plan.push_back(step_of(STEP_REQ, imm_pkg::ACT_WR_B, 0, 0, 32'hFFFF_FFFF, 0, '0));
		plan.push_back(step_of(STEP_REQ, imm_pkg::ACT_WR_B, 0, 1, 32'h8000_0000, 0, '0));
		plan.push_back(step_of(STEP_REQ, imm_pkg::ACT_WR_B, 1, 0, 32'h0000_0001, 0, '0));
		plan.push_back(step_of(STEP_REQ, imm_pkg::ACT_WR_B, 1, 1, 32'hFFFF_FFFF, 0, '0));
		plan.push_back(step_of(STEP_REQ, imm_pkg::ACT_COMP, 0, 63, 32'hFFFF_FFFF, 0, '0));
		plan.push_back(step_of(STEP_REQ, imm_pkg::ACT_COMP, 2, 0, 0, 1,
			mk_result(2, 0, 0, 1, 1)));
		plan.push_back(step_of(STEP_REQ, imm_pkg::ACT_COMP, 63, 0, 0, 1,
			mk_result(63, 0, 0, 1, 1)));
		plan.push_back(step_of(STEP_REQ, ACT_UNUSED, 63, 63, 32'hFFFF_FFFF, 0, '0));
		plan.push_back(step_of(STEP_REQ, imm_pkg::ACT_WR_A, 63, 63, 32'hFFFF_FFFF, 0, '0));
		plan.push_back(step_of(STEP_REG, imm_pkg::REG_B_COLS, 0, 0, 0, 0, '0));
		plan.push_back(step_of(STEP_REQ, imm_pkg::ACT_COMP, 1, 0, 0, 0, '0));
		plan.push_back(step_of(STEP_REG, imm_pkg::REG_B_COLS, 0, 0, 1, 0, '0));
		plan.push_back(step_of(STEP_REG, imm_pkg::REG_INNER, 0, 0, 0, 0, '0));
		plan.push_back(step_of(STEP_REQ, imm_pkg::ACT_COMP, 1, 0, 0, 1,
			mk_result(1, 0, 0, 1, 0)));
		plan.push_back(step_of(STEP_REG, imm_pkg::REG_A_ROWS, 0, 0, 0, 0, '0));
		plan.push_back(step_of(STEP_REQ, imm_pkg::ACT_COMP, 0, 0, 0, 1,
			mk_result(0, 0, 0, 1, 1)));
		plan.push_back(step_of(STEP_REG, imm_pkg::REG_A_ROWS, 0, 0, 127, 0, '0));
		plan.push_back(step_of(STEP_REQ, imm_pkg::ACT_COMP, 63, 0, 0, 1,
			mk_result(63, 0, 0, 1, 0)));
		plan.push_back(step_of(STEP_REG, imm_pkg::REG_INNER, 0, 0, 127, 0, '0));
		plan.push_back(step_of(STEP_REQ, imm_pkg::ACT_COMP, 63, 0, 0, 0, '0));
		plan.push_back(step_of(STEP_REG, imm_pkg::REG_INNER, 0, 0, 1, 0, '0));
		plan.push_back(step_of(STEP_REG, imm_pkg::REG_B_COLS, 0, 0, 64, 0, '0));
		plan.push_back(step_of(STEP_REQ, imm_pkg::ACT_COMP, 0, 0, 0, 0, '0));

		foreach (plan[i]) begin
			if (plan[i].kind == STEP_REG)
				write_reg(plan[i].code, plan[i].value[imm_pkg::REG_W-1:0]);
			else begin
				if (plan[i].code == imm_pkg::ACT_COMP)
					fill_operands(plan[i].row);
				push_request(plan[i].code, plan[i].row, plan[i].col, plan[i].value,
					plan[i].typed, plan[i].want);
			end
		end

		// random part: one setting of all three registers per phase, then a burst of requests;
		// operand loads count toward the budget
		phase = 0;
		stop_at = requests_sent + RANDOM_ITEMS;
		while (requests_sent < stop_at) begin
			phase++;
			dim_a = pick_dim();
			dim_k = pick_dim();
			dim_n = pick_dim();
			// keep the B operand block modest
			if (clip_dim(dim_k) * clip_dim(dim_n) > 512)
				dim_n = 7'($urandom_range(1, 6));
			write_reg(imm_pkg::REG_A_ROWS, dim_a);
			write_reg(imm_pkg::REG_INNER, dim_k);
			write_reg(imm_pkg::REG_B_COLS, dim_n);
			// a long stretch with no idling on either side
			gaps_on = (phase > 2);
			rows = clip_dim(cfg_a_rows);
			picks = $urandom_range(10, 20);
			for (int n = 0; n < picks && requests_sent < stop_at; n++) begin
				pick = $urandom_range(99);
				if (pick < 70 && rows > 0 && (pick < 55 || rows == imm_pkg::MAX_DIM_DEF)) begin
					row = imm_pkg::IDX_W'($urandom_range(rows - 1));
					fill_operands(row);
					push_request(imm_pkg::ACT_COMP, row, imm_pkg::IDX_W'($urandom), $urandom,
						1'b0, '0);
				end else if (pick < 70) begin
					row = imm_pkg::IDX_W'($urandom_range(rows, imm_pkg::MAX_DIM_DEF - 1));
					push_request(imm_pkg::ACT_COMP, row, imm_pkg::IDX_W'($urandom), $urandom,
						1'b0, '0);
				end else if (pick < 92)
					push_request($urandom_range(1) ? imm_pkg::ACT_WR_B : imm_pkg::ACT_WR_A,
						imm_pkg::IDX_W'($urandom), imm_pkg::IDX_W'($urandom), rand_elem(),
						1'b0, '0);
				else
					push_request(ACT_UNUSED, imm_pkg::IDX_W'($urandom),
						imm_pkg::IDX_W'($urandom), $urandom, 1'b0, '0);
			end
		end
		random_sent = requests_sent - (stop_at - RANDOM_ITEMS);
		gaps_on = 1'b1;

		settle();
		$display("Sent %0d requests (%0d random) over %0d register writes; checked %0d results.",
			requests_sent, random_sent, settings_used, results_seen);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
